[hdl/scs_pkg.sv]
// Package with shared types, constants and opcodes of the 16-bit core.
`default_nettype none
package scs_pkg;

  localparam int unsigned MemWords = 4096;
  localparam int unsigned NumRegs  = 16;
  localparam int unsigned DataW    = 16;

  localparam logic [3:0] LinkReg = 4'd13;

  localparam logic [1:0] StExec  = 2'd0;
  localparam logic [1:0] StHalt  = 2'd1;
  localparam logic [1:0] StUnk   = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  localparam logic [7:0] OpSet   = 8'd1;
  localparam logic [7:0] OpCopy  = 8'd2;
  localparam logic [7:0] OpAdd   = 8'd3;
  localparam logic [7:0] OpCmp   = 8'd8;
  localparam logic [7:0] OpNot   = 8'd16;
  localparam logic [7:0] OpAddI  = 8'd17;
  localparam logic [7:0] OpCmpI  = 8'd22;
  localparam logic [7:0] OpNorI  = 8'd29;
  localparam logic [7:0] OpLoad  = 8'd30;
  localparam logic [7:0] OpStore = 8'd31;
  localparam logic [7:0] OpJmp   = 8'd32;
  localparam logic [7:0] OpJz    = 8'd33;
  localparam logic [7:0] OpJnz   = 8'd34;
  localparam logic [7:0] OpJal   = 8'd35;
  localparam logic [7:0] OpHalt  = 8'd36;

  // ALU function codes (opcode minus base).
  localparam logic [3:0] AluAdd  = 4'd0;
  localparam logic [3:0] AluSub  = 4'd1;
  localparam logic [3:0] AluMul  = 4'd2;
  localparam logic [3:0] AluDiv  = 4'd3;
  localparam logic [3:0] AluMod  = 4'd4;
  localparam logic [3:0] AluCmp  = 4'd5;
  localparam logic [3:0] AluShl  = 4'd6;
  localparam logic [3:0] AluShr  = 4'd7;
  localparam logic [3:0] AluAnd  = 4'd8;
  localparam logic [3:0] AluOr   = 4'd9;
  localparam logic [3:0] AluXor  = 4'd10;
  localparam logic [3:0] AluNand = 4'd11;
  localparam logic [3:0] AluNor  = 4'd12;

  typedef struct packed {
    logic        action;
    logic [15:0] word_addr;
    logic [15:0] word_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc_after;
    logic [7:0]  opcode_run;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic        zero_out;
    logic        sign_out;
    logic        mem_written;
    logic [15:0] mem_addr;
    logic [15:0] mem_value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mem_clr;      // write zero at the clear counter and advance it
    logic mem_sel_wr;   // memory address from the write item
    logic mem_sel_pc1;  // memory address is pc+1
    logic mem_sel_ea;   // memory address is the effective address
    logic mem_we_item;
    logic mem_we_store;
    logic lat_hi;
    logic lat_lo;
    logic lat_ld;
    logic div_start;
    logic commit;
    logic res_write;
    logic res_stopped;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       stopped;
    logic [7:0] opcode;
    logic       div_busy;
    logic       need_div;
  } sts_t;

endpackage
`default_nettype wire

[hdl/scs_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module scs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[hdl/scs_div.sv]
// Iterative 16-bit restoring divider, one quotient bit per cycle.
`default_nettype none
module scs_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             busy_o,
  output logic      [15:0] quot_o,
  output logic      [15:0] rem_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [16:0] trial;

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[15]} - {1'b0, dvs_q};
    if (start_i) begin
      cnt_d  = 5'd16;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      if (!trial[16]) begin
        rem_d  = trial[15:0];
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        rem_d  = {rem_q[14:0], quot_q[15]};
        quot_d = {quot_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = (cnt_q != 5'd0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

[hdl/scs_datapath.sv]
// Datapath: word memory, register file, flags, pc, ALU, divider, result register.
`default_nettype none
module scs_datapath #(
  parameter int unsigned MemWords = scs_pkg::MemWords
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scs_pkg::in_item_t item_i,
  input  wire scs_pkg::cmd_t     cmd_i,
  output scs_pkg::sts_t          sts_o,
  output scs_pkg::out_item_t     res_o
);
  localparam int unsigned AW = $clog2(MemWords);

  logic [15:0] pc_q, pc_d;
  logic        zf_q, zf_d, sf_q, sf_d, stop_q, stop_d;
  logic [15:0] rf_q [scs_pkg::NumRegs];
  logic [15:0] hi_q, lo_q, ld_q;
  logic [AW-1:0] clr_q;
  scs_pkg::out_item_t res_q, res_d;

  logic [15:0] mem_rdata, mem_wdata, pc1, ea, a, b, alu_y, rdv, wb_val, store_v;
  logic [AW-1:0] mem_addr;
  logic [7:0]  opc;
  logic [3:0]  rd, r1, r2, alu_fn, wb_idx;
  logic [15:0] imm;
  logic        is_rr, is_ri, wb, setf, mem_we, div_busy, stop_n;
  logic [1:0]  st;
  logic [15:0] quot, remd, pc_n;
  logic [31:0] prod;

  assign opc = hi_q[15:8];
  assign rd  = hi_q[7:4];
  assign r1  = hi_q[3:0];
  assign r2  = lo_q[15:12];
  assign imm = lo_q;
  assign pc1 = pc_q + 16'd1;

  assign a   = (r1 == 4'd0) ? 16'd0 : rf_q[r1];
  assign rdv = (rd == 4'd0) ? 16'd0 : rf_q[rd];
  assign ea  = a + imm;
  assign store_v = rdv;

  assign is_rr = (opc >= scs_pkg::OpAdd) && (opc <= scs_pkg::OpNot);
  assign is_ri = (opc >= scs_pkg::OpAddI) && (opc <= scs_pkg::OpNorI);
  assign b = is_rr ? ((r2 == 4'd0) ? 16'd0 : rf_q[r2]) : imm;
  assign alu_fn = is_rr ? 4'(opc - scs_pkg::OpAdd) : 4'(opc - scs_pkg::OpAddI);

  always_comb begin
    priority case (1'b1)
      cmd_i.mem_clr:     mem_addr = clr_q;
      cmd_i.mem_sel_wr:  mem_addr = item_i.word_addr[AW-1:0];
      cmd_i.mem_sel_pc1: mem_addr = pc1[AW-1:0];
      cmd_i.mem_sel_ea:  mem_addr = ea[AW-1:0];
      default:           mem_addr = pc_q[AW-1:0];
    endcase
  end
  assign mem_we    = cmd_i.mem_clr | cmd_i.mem_we_item | cmd_i.mem_we_store;
  assign mem_wdata = cmd_i.mem_clr ? 16'd0
                   : (cmd_i.mem_we_item ? item_i.word_data : store_v);

  scs_ram #(.Width(16), .Depth(MemWords)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  scs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a),
    .divisor_i  (b),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (remd)
  );

  assign prod = 32'(a) * 32'(b);

  always_comb begin
    unique case (alu_fn)
      scs_pkg::AluAdd:  alu_y = a + b;
      scs_pkg::AluSub,
      scs_pkg::AluCmp:  alu_y = a - b;
      scs_pkg::AluMul:  alu_y = prod[15:0];
      scs_pkg::AluDiv:  alu_y = (b == 16'd0) ? 16'hFFFF : quot;
      scs_pkg::AluMod:  alu_y = (b == 16'd0) ? a : remd;
      scs_pkg::AluShl:  alu_y = (b >= 16'd16) ? 16'd0 : (a << b[3:0]);
      scs_pkg::AluShr:  alu_y = (b >= 16'd16) ? 16'd0 : (a >> b[3:0]);
      scs_pkg::AluAnd:  alu_y = a & b;
      scs_pkg::AluOr:   alu_y = a | b;
      scs_pkg::AluXor:  alu_y = a ^ b;
      scs_pkg::AluNand: alu_y = ~(a & b);
      scs_pkg::AluNor:  alu_y = ~(a | b);
      default:          alu_y = ~a;
    endcase
  end

  always_comb begin
    pc_n   = pc_q + 16'd2;
    wb     = 1'b0;
    wb_idx = rd;
    wb_val = alu_y;
    setf   = 1'b0;
    st     = scs_pkg::StExec;
    stop_n = 1'b0;
    if (opc == scs_pkg::OpSet) begin
      wb = 1'b1; wb_val = imm;
    end else if (opc == scs_pkg::OpCopy) begin
      wb = 1'b1; wb_val = a;
    end else if (is_rr) begin
      setf = 1'b1; wb = (opc != scs_pkg::OpCmp);
    end else if (is_ri) begin
      setf = 1'b1; wb = (opc != scs_pkg::OpCmpI);
    end else if (opc == scs_pkg::OpLoad) begin
      wb = 1'b1; wb_val = ld_q;
    end else if (opc == scs_pkg::OpStore) begin
      wb = 1'b0;
    end else if (opc == scs_pkg::OpJmp) begin
      pc_n = imm;
    end else if (opc == scs_pkg::OpJz) begin
      if (zf_q) pc_n = imm;
    end else if (opc == scs_pkg::OpJnz) begin
      if (!zf_q) pc_n = imm;
    end else if (opc == scs_pkg::OpJal) begin
      wb = 1'b1; wb_idx = scs_pkg::LinkReg; wb_val = pc_q + 16'd2; pc_n = imm;
    end else if (opc == scs_pkg::OpHalt) begin
      stop_n = 1'b1; st = scs_pkg::StHalt;
    end else begin
      stop_n = 1'b1; st = scs_pkg::StUnk;
    end
    if (wb_idx == 4'd0) wb = 1'b0;
  end

  always_comb begin
    pc_d   = pc_q;
    zf_d   = zf_q;
    sf_d   = sf_q;
    stop_d = stop_q;
    res_d  = res_q;
    if (cmd_i.commit) begin
      pc_d   = pc_n;
      stop_d = stop_n;
      if (setf) begin
        zf_d = (alu_y == 16'd0);
        sf_d = alu_y[15];
      end
    end
    if (cmd_i.res_write) begin
      res_d = '0;
      res_d.zero_out = zf_d;
      res_d.sign_out = sf_d;
      res_d.pc_after = pc_d;
      if (cmd_i.mem_we_item) begin
        res_d.status = scs_pkg::StWrite;
      end else if (cmd_i.res_stopped) begin
        res_d.status = scs_pkg::StHalt;
      end else begin
        res_d.status      = st;
        res_d.opcode_run  = opc;
        res_d.reg_written = wb;
        res_d.reg_index   = wb ? wb_idx : 4'd0;
        res_d.reg_value   = wb ? wb_val : 16'd0;
        if (opc == scs_pkg::OpStore) begin
          res_d.mem_written = 1'b1;
          res_d.mem_addr    = 16'(ea[AW-1:0]);
          res_d.mem_value   = store_v;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      zf_q   <= 1'b0;
      sf_q   <= 1'b0;
      stop_q <= 1'b0;
      clr_q  <= '0;
      for (int i = 0; i < scs_pkg::NumRegs; i++) rf_q[i] <= '0;
    end else begin
      pc_q   <= pc_d;
      zf_q   <= zf_d;
      sf_q   <= sf_d;
      stop_q <= stop_d;
      if (cmd_i.mem_clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.commit && wb) rf_q[wb_idx] <= wb_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_hi) hi_q <= mem_rdata;
    if (cmd_i.lat_lo) lo_q <= mem_rdata;
    if (cmd_i.lat_ld) ld_q <= mem_rdata;
    res_q <= res_d;
  end

  assign sts_o.clr_last = &clr_q;
  assign sts_o.stopped  = stop_q;
  assign sts_o.opcode   = opc;
  assign sts_o.div_busy = div_busy;
  assign sts_o.need_div = (is_rr && (alu_fn == scs_pkg::AluDiv || alu_fn == scs_pkg::AluMod))
                       || (is_ri && (alu_fn == scs_pkg::AluDiv || alu_fn == scs_pkg::AluMod));
  assign res_o = res_q;
endmodule
`default_nettype wire

[hdl/scs_ctrl.sv]
// Controller state machine sequencing fetch, execute and result hand-off.
`default_nettype none
module scs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire scs_pkg::in_item_t item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire scs_pkg::sts_t     sts_i,
  output scs_pkg::cmd_t          cmd_o
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SFHi   = 3'd1;
  localparam logic [2:0] SFLo   = 3'd2;
  localparam logic [2:0] SDec   = 3'd3;
  localparam logic [2:0] SDiv   = 3'd4;
  localparam logic [2:0] SLoad  = 3'd5;
  localparam logic [2:0] SExec  = 3'd6;
  localparam logic [2:0] SClr   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       accept;

  // A new transaction is taken in the idle state once the result register is free or draining.
  assign in_ready_o = (state_q == SIdle) && (!ov_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      // After reset every memory word is written with zero, one per cycle.
      SClr: begin
        cmd_o.mem_clr = 1'b1;
        if (sts_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        if (accept) begin
          if (!item_i.action) begin
            cmd_o.mem_sel_wr  = 1'b1;
            cmd_o.mem_we_item = 1'b1;
            cmd_o.res_write   = 1'b1;
            ov_d = 1'b1;
          end else if (sts_i.stopped) begin
            cmd_o.res_write   = 1'b1;
            cmd_o.res_stopped = 1'b1;
            ov_d = 1'b1;
          end else begin
            state_d = SFHi;
          end
        end
      end
      SFHi: begin
        cmd_o.mem_sel_pc1 = 1'b1;
        cmd_o.lat_hi      = 1'b1;
        state_d = SFLo;
      end
      SFLo: begin
        cmd_o.lat_lo = 1'b1;
        state_d = SDec;
      end
      SDec: begin
        cmd_o.mem_sel_ea = 1'b1;
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv;
        end else if (sts_i.opcode == scs_pkg::OpLoad) begin
          state_d = SLoad;
        end else begin
          state_d = SExec;
        end
      end
      SDiv: begin
        if (!sts_i.div_busy) state_d = SExec;
      end
      SLoad: begin
        cmd_o.lat_ld = 1'b1;
        state_d = SExec;
      end
      SExec: begin
        cmd_o.mem_sel_ea   = 1'b1;
        cmd_o.mem_we_store = (sts_i.opcode == scs_pkg::OpStore);
        cmd_o.commit       = 1'b1;
        if (!ov_q || out_ready_i) begin
          cmd_o.res_write = 1'b1;
          ov_d    = 1'b1;
          state_d = SIdle;
        end else begin
          cmd_o.commit       = 1'b0;
          cmd_o.mem_we_store = 1'b0;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

[hdl/sixteen_bit_cpu_core_step_top.sv]
// Top level: 16-bit core stepped one transaction at a time.
// A write transaction or a step while stopped gives its result in the cycle after acceptance.
// A step fetches its two words over the single memory port, decodes and executes before the
// next item is taken; a load adds a read state, a divide or modulo waits on the divider.
// Reset clears registers, flags, pc and the stopped bit, then zeroes all MemWords memory words
// (4096 by default) with the input not ready.
`default_nettype none
module sixteen_bit_cpu_core_step_top #(
  parameter int unsigned MemWords = scs_pkg::MemWords
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire scs_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output scs_pkg::out_item_t       out_data_o
);
  scs_pkg::cmd_t cmd;
  scs_pkg::sts_t sts;

  scs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_i      (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scs_datapath #(.MemWords(MemWords)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_data_o)
  );
endmodule
`default_nettype wire

[test/tb_sixteen_bit_cpu_core_step_top.sv]
// Testbench for the 16-bit core: directed and random instructions written to memory, then stepped and checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_sixteen_bit_cpu_core_step_top;

  localparam int unsigned WatchLimit = 20000;

  class core_scoreboard;
    logic [15:0] regs[16];
    logic [15:0] pc;
    bit          zf, sf, halted;
    logic [15:0] mem[scs_pkg::MemWords];
    bit          written[scs_pkg::MemWords];
    scs_pkg::out_item_t pending[$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) begin
        mem[i] = '0;
        written[i] = 1'b0;
      end
      pc = '0;
      zf = 0;
      sf = 0;
      halted = 0;
      errors = 0;
    endfunction

    function int widx(logic [15:0] a);
      return int'(a) % scs_pkg::MemWords;
    endfunction

    function logic [15:0] rget(logic [3:0] i);
      return (i == 4'd0) ? 16'd0 : regs[i];
    endfunction

    function logic [15:0] alu_calc(logic [3:0] f, logic [15:0] a, logic [15:0] b);
      logic [31:0] prod;
      prod = a * b;
      case (f)
        scs_pkg::AluAdd:  return a + b;
        scs_pkg::AluSub:  return a - b;
        scs_pkg::AluMul:  return prod[15:0];
        scs_pkg::AluDiv:  return (b == 0) ? 16'hFFFF : a / b;
        scs_pkg::AluMod:  return (b == 0) ? a : a % b;
        scs_pkg::AluCmp:  return a - b;
        scs_pkg::AluShl:  return (b >= 16) ? 16'd0 : a << b;
        scs_pkg::AluShr:  return (b >= 16) ? 16'd0 : a >> b;
        scs_pkg::AluAnd:  return a & b;
        scs_pkg::AluOr:   return a | b;
        scs_pkg::AluXor:  return a ^ b;
        scs_pkg::AluNand: return ~(a & b);
        scs_pkg::AluNor:  return ~(a | b);
        default:          return ~a;
      endcase
    endfunction

    // Applies one accepted transaction to the core state and queues its result.
    function void note_input(scs_pkg::in_item_t it);
      scs_pkg::out_item_t e;
      logic [15:0] hi, lo, val;
      logic [3:0]  rd, r1, r2;
      logic [7:0]  opc;
      bit          wr;
      int          ea;
      e = '0;
      if (!it.action) begin
        mem[widx(it.word_addr)] = it.word_data;
        written[widx(it.word_addr)] = 1'b1;
        e.status = scs_pkg::StWrite;
      end else if (halted) begin
        e.status = scs_pkg::StHalt;
      end else begin
        hi = mem[widx(pc)];
        lo = mem[widx(pc + 16'd1)];
        opc = hi[15:8];
        rd = hi[7:4];
        r1 = hi[3:0];
        r2 = lo[15:12];
        wr = 0;
        val = '0;
        e.status = scs_pkg::StExec;
        e.opcode_run = opc;
        pc = pc + 16'd2;
        if (opc == scs_pkg::OpSet) begin
          wr = 1;
          val = lo;
        end else if (opc == scs_pkg::OpCopy) begin
          wr = 1;
          val = rget(r1);
        end else if (opc >= scs_pkg::OpAdd && opc <= scs_pkg::OpNot) begin
          val = alu_calc(4'(opc - scs_pkg::OpAdd), rget(r1), rget(r2));
          zf = (val == 0);
          sf = val[15];
          wr = (opc != scs_pkg::OpCmp);
        end else if (opc >= scs_pkg::OpAddI && opc <= scs_pkg::OpNorI) begin
          val = alu_calc(4'(opc - scs_pkg::OpAddI), rget(r1), lo);
          zf = (val == 0);
          sf = val[15];
          wr = (opc != scs_pkg::OpCmpI);
        end else if (opc == scs_pkg::OpLoad) begin
          wr = 1;
          val = mem[widx(rget(r1) + lo)];
        end else if (opc == scs_pkg::OpStore) begin
          ea = widx(rget(r1) + lo);
          e.mem_written = 1;
          e.mem_addr = 16'(ea);
          e.mem_value = rget(rd);
          mem[ea] = rget(rd);
          written[ea] = 1'b1;
        end else if (opc == scs_pkg::OpJmp) begin
          pc = lo;
        end else if (opc == scs_pkg::OpJz) begin
          if (zf) pc = lo;
        end else if (opc == scs_pkg::OpJnz) begin
          if (!zf) pc = lo;
        end else if (opc == scs_pkg::OpJal) begin
          wr = 1;
          rd = scs_pkg::LinkReg;
          val = pc;
          pc = lo;
        end else if (opc == scs_pkg::OpHalt) begin
          halted = 1;
          e.status = scs_pkg::StHalt;
        end else begin
          halted = 1;
          e.status = scs_pkg::StUnk;
        end
        if (wr && rd != 4'd0) begin
          regs[rd] = val;
          e.reg_written = 1;
          e.reg_index = rd;
          e.reg_value = val;
        end
      end
      e.pc_after = pc;
      e.zero_out = zf;
      e.sign_out = sf;
      pending.push_back(e);
    endfunction

    function void check_result(scs_pkg::out_item_t got);
      scs_pkg::out_item_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.pc_after !== e.pc_after
          || got.opcode_run !== e.opcode_run || got.reg_written !== e.reg_written
          || got.reg_index !== e.reg_index || got.reg_value !== e.reg_value
          || got.zero_out !== e.zero_out || got.sign_out !== e.sign_out
          || got.mem_written !== e.mem_written || got.mem_addr !== e.mem_addr
          || got.mem_value !== e.mem_value) begin
        errors++;
        if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", e, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  scs_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  scs_pkg::out_item_t out_data;

  core_scoreboard sb = new();
  bit quiet = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stalling = 0;

  always #1 clk = ~clk;

  sixteen_bit_cpu_core_step_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Result side: check accepted transactions and drive ready in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_sixteen_bit_cpu_core_step_top: done, errors");
        $finish;
      end
      if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        if (stall_left == 0) begin
          stalling = ($urandom_range(0, 3) == 0);
          stall_left = stalling ? $urandom_range(1, 13) : $urandom_range(1, 20);
        end
        stall_left--;
        out_ready <= !stalling;
      end
    end
  end

  task automatic send(input bit act, input logic [15:0] addr, input logic [15:0] data);
    int gap;
    scs_pkg::in_item_t it;
    it.action = act;
    it.word_addr = addr;
    it.word_data = data;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Writes one instruction at pc (and any load operand not yet written), then steps it.
  task automatic run_instr(input logic [7:0] opc, input logic [3:0] rd, input logic [3:0] r1,
                           input logic [15:0] lo);
    int ea;
    if (opc == scs_pkg::OpLoad) begin
      ea = sb.widx(sb.rget(r1) + lo);
      if (!sb.written[ea]) send(1'b0, 16'(ea), 16'($urandom));
    end
    send(1'b0, sb.pc, {opc, rd, r1});
    send(1'b0, sb.pc + 16'd1, lo);
    send(1'b1, 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 20));
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] opc;
    logic [15:0] lo;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme operands, zero divisor, big shifts, writes to r0.
    run_instr(scs_pkg::OpSet, 4'd1, 4'd0, 16'hFFFF);
    run_instr(scs_pkg::OpSet, 4'd2, 4'd0, 16'h8000);
    run_instr(scs_pkg::OpSet, 4'd15, 4'd0, 16'd16);
    for (int o = scs_pkg::OpCopy; o < scs_pkg::OpHalt; o++) begin
      opc = 8'(o);
      lo = (o >= scs_pkg::OpAddI && o <= scs_pkg::OpNorI)
           ? ((o % 2 == 0) ? 16'd0 : 16'd16) : {4'd3, 12'hFFF};
      if (o >= scs_pkg::OpLoad) lo = 16'($urandom);
      run_instr(opc, (o % 5 == 0) ? 4'd0 : 4'(o % 16), (o % 2 == 0) ? 4'd1 : 4'd2, lo);
    end
    send(1'b0, 16'hFFFF, 16'hFFFF);
    send(1'b0, 16'h0000, 16'h0000);

    // Random programs with some stray data writes.
    for (int n = 0; n < 170; n++) begin
      if (n == 145) quiet = 1;
      if ($urandom_range(0, 9) == 0) send(1'b0, 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 9) < 2) opc = scs_pkg::OpSet;
      else opc = 8'($urandom_range(scs_pkg::OpCopy, scs_pkg::OpJal));
      lo = (opc >= scs_pkg::OpAdd && opc <= scs_pkg::OpNot)
           ? {4'($urandom), 12'($urandom)} : rand_imm();
      run_instr(opc, 4'($urandom), 4'($urandom), lo);
    end

    // The core can stop only once: end with a halt or an unknown opcode.
    if ($urandom_range(0, 1) == 0) opc = scs_pkg::OpHalt;
    else if ($urandom_range(0, 3) == 0) opc = 8'd0;
    else opc = 8'($urandom_range(scs_pkg::OpHalt + 1, 255));
    run_instr(opc, 4'($urandom), 4'($urandom), 16'($urandom));
    send(1'b1, 16'd0, 16'd0);
    send(1'b0, 16'($urandom), 16'($urandom));
    send(1'b1, 16'd0, 16'd0);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_sixteen_bit_cpu_core_step_top: done, clean");
    end else begin
      $display("tb_sixteen_bit_cpu_core_step_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
